// ===== hdl/bcmw_pkg.sv =====
// Shared types, constants and coding tables of the Brotli copy meta-block writer.
package bcmw_pkg;

	localparam int unsigned MAX_BLOCK_LEN = 1 << 24;
	localparam int BITS_W = 144;
	localparam int POS_W = 8;
	localparam int SRC_W = BITS_W + 8;

	typedef enum logic [1:0] {
		CMD_COPY      = 2'd0,
		CMD_RAW_START = 2'd1,
		CMD_RAW_BYTE  = 2'd2,
		CMD_END       = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ERR_NONE     = 2'd0,
		ERR_LENGTH   = 2'd1,
		ERR_DISTANCE = 2'd2
	} err_t;

	localparam logic [1:0] REG_WINDOW_LOG   = 2'd0;
	localparam logic [1:0] REG_WINDOW_BYTES = 2'd1;
	localparam logic [1:0] REG_DICT_BYTES   = 2'd2;

	localparam logic [27:0] DIST_P0_MAX = 28'd67108860;
	localparam logic [27:0] DIST_P1_MAX = 28'd134217720;
	localparam logic [27:0] DIST_P2_MAX = 28'd268435440;

	typedef struct packed {
		logic [4:0]  window_log;
		logic [23:0] window_bytes;
		logic [24:0] dict_bytes;
	} cfg_t;

	// One queued word: the bits an item adds to the stream, LSB first.
	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic [POS_W-1:0]  len;
		logic              pad;
		err_t              err;
	} entry_t;

	function automatic logic [BITS_W-1:0] put_bits(logic [BITS_W-1:0] acc,
			logic [POS_W-1:0] pos, logic [31:0] val, logic [5:0] n);
		logic [BITS_W-1:0] mask;
		mask = (BITS_W'(1) << n) - BITS_W'(1);
		return acc | ((BITS_W'(val) & mask) << pos);
	endfunction

	function automatic logic [6:0] wh_val(logic [3:0] w);
		case (w)
			4'd0: return 7'h21;
			4'd1: return 7'h31;
			4'd2: return 7'h41;
			4'd3: return 7'h51;
			4'd4: return 7'h61;
			4'd5: return 7'h71;
			4'd6: return 7'h00;
			4'd7: return 7'h01;
			4'd8: return 7'h03;
			4'd9: return 7'h05;
			4'd10: return 7'h07;
			4'd11: return 7'h09;
			4'd12: return 7'h0B;
			4'd13: return 7'h0D;
			default: return 7'h0F;
		endcase
	endfunction

	function automatic logic [2:0] wh_len(logic [3:0] w);
		case (w)
			4'd6: return 3'd1;
			4'd7, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5: return 3'd7;
			default: return 3'd4;
		endcase
	endfunction

	function automatic logic [4:0] copy_xbits(logic [4:0] c);
		case (c)
			5'd8, 5'd9: return 5'd1;
			5'd10, 5'd11: return 5'd2;
			5'd12, 5'd13: return 5'd3;
			5'd14, 5'd15: return 5'd4;
			5'd16, 5'd17: return 5'd5;
			5'd18: return 5'd6;
			5'd19: return 5'd7;
			5'd20: return 5'd8;
			5'd21: return 5'd9;
			5'd22: return 5'd10;
			5'd23: return 5'd24;
			default: return 5'd0;
		endcase
	endfunction

	// Largest copy length that each insert-and-copy length code from 0 to 22 covers.
	function automatic logic [11:0] copy_maxl(logic [4:0] c);
		case (c)
			5'd0: return 12'd2;
			5'd1: return 12'd3;
			5'd2: return 12'd4;
			5'd3: return 12'd5;
			5'd4: return 12'd6;
			5'd5: return 12'd7;
			5'd6: return 12'd8;
			5'd7: return 12'd9;
			5'd8: return 12'd11;
			5'd9: return 12'd13;
			5'd10: return 12'd17;
			5'd11: return 12'd21;
			5'd12: return 12'd29;
			5'd13: return 12'd37;
			5'd14: return 12'd53;
			5'd15: return 12'd69;
			5'd16: return 12'd101;
			5'd17: return 12'd133;
			5'd18: return 12'd197;
			5'd19: return 12'd325;
			5'd20: return 12'd581;
			5'd21: return 12'd1093;
			default: return 12'd2117;
		endcase
	endfunction

endpackage

// ===== hdl/brotli_copy_metablock_writer_core.sv =====
// Top level of the Brotli copy meta-block writer: registers, front, queue and packer.
//
// Commands enter on the in_valid/in_ready channel: copy from the dictionary, raw block
// start, raw byte and end of stream. Each command yields one or more output words on
// out_valid/out_ready, one compressed stream byte per word, least significant bit first;
// last marks the final word of a command and error flags a rejected copy or raw start.
// Configuration words arrive on cfg_valid/cfg_ready (always ready) and must only be
// written while the block is idle.
// The first output word of a command passes the accept register, the second coding
// stage and the queue before it reaches the output register, and any wait for a busy
// packer in the two-word queue comes on top.
// A command is accepted every cycle while the queue has room. The packer emits one byte
// per cycle while the receiver is ready, so a raw byte passes at one per cycle, and a
// copy holds the packer until its last byte is out; the packer sets the sustained rate.
// Reset clears the byte count, the partial byte, the queue and all valid flags and loads
// the register defaults. When the receiver stalls, the output word holds, the queue fills
// and in_ready drops; nothing is lost.
module brotli_copy_metablock_writer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [25:0] dict_offset,
	input  logic [24:0] byte_length,
	input  logic [7:0]  raw_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic [1:0]  error,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [24:0] cfg_data
);

	bcmw_pkg::cfg_t   cfg_q;
	bcmw_pkg::entry_t wentry, rentry;
	logic push, full, pop, empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_log <= 5'd22;
			cfg_q.window_bytes <= 24'd4194288;
			cfg_q.dict_bytes <= 25'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bcmw_pkg::REG_WINDOW_LOG: cfg_q.window_log <= cfg_data[4:0];
				bcmw_pkg::REG_WINDOW_BYTES: cfg_q.window_bytes <= cfg_data[23:0];
				bcmw_pkg::REG_DICT_BYTES: cfg_q.dict_bytes <= cfg_data;
				default: ;
			endcase
		end
	end

	bcmw_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
		.dict_offset(dict_offset), .byte_length(byte_length), .raw_value(raw_value),
		.push(push), .full(full), .entry(wentry)
	);

	bcmw_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(wentry), .full(full),
		.pop(pop), .empty(empty), .rdata(rentry)
	);

	bcmw_back u_back (
		.clk(clk), .arst_n(arst_n), .empty(empty), .head(rentry), .pop(pop),
		.out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
		.last(last), .error(error)
	);

	// A rejected command is always a single zero word.
	a_err_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error != bcmw_pkg::ERR_NONE |-> last && out_byte == 8'd0)
		else $error("error word not a single zero byte");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> error != 2'd3)
		else $error("undefined error code");

	// The queue is never popped empty nor pushed full.
	a_queue: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty) && !(push && full))
		else $error("queue overrun or underrun");

endmodule

// ===== hdl/bcmw_front.sv =====
// Front part: accepts commands, checks them and builds the bit word of each item.
module bcmw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bcmw_pkg::cfg_t       cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	input  logic [25:0]          dict_offset,
	input  logic [24:0]          byte_length,
	input  logic [7:0]           raw_value,
	output logic                 push,
	input  logic                 full,
	output bcmw_pkg::entry_t     entry
);

	logic [31:0] emitted_q;

	logic        v_s1;
	logic [1:0]  cmd_s1;
	logic [24:0] len_s1;
	logic [25:0] d_s1;
	logic [1:0]  err_s1;
	logic        hdr_s1;
	logic [7:0]  rv_s1;

	logic                    v_s2;
	logic [1:0]              cmd_s2;
	logic [1:0]              err_s2;
	logic [bcmw_pkg::BITS_W-1:0] acc_s2;
	logic [bcmw_pkg::POS_W-1:0]  pos_s2;
	logic [23:0]             cx_s2;
	logic [4:0]              nx_s2;
	logic [1:0]              p_s2;
	logic [26:0]             dist_s2;
	logic [4:0]              bucket_s2;
	logic [7:0]              rv_s2;

	logic rdy1, rdy2, accept;

	assign rdy2 = !v_s2 || !full;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;
	assign accept = in_valid && rdy1;
	assign push = v_s2 && !full;

	// Accept stage: distance base, checks and byte count.
	logic [23:0] win_min;
	logic [25:0] base;
	logic [1:0]  err_a;
	logic [32:0] sum;
	logic        bad_len;

	always_comb begin
		win_min = (32'(cfg.window_bytes) < emitted_q) ? cfg.window_bytes : emitted_q[23:0];
		base = 26'(cfg.dict_bytes) + 26'(win_min);
		sum = 33'(emitted_q) + 33'(byte_length);
		bad_len = (byte_length > 25'(bcmw_pkg::MAX_BLOCK_LEN)) || (byte_length == 25'd0);
		err_a = bcmw_pkg::ERR_NONE;
		case (bcmw_pkg::cmd_t'(cmd))
			bcmw_pkg::CMD_COPY: begin
				if (bad_len || byte_length == 25'd1)
					err_a = bcmw_pkg::ERR_LENGTH;
				else if (dict_offset >= base)
					err_a = bcmw_pkg::ERR_DISTANCE;
			end
			bcmw_pkg::CMD_RAW_START: begin
				if (bad_len)
					err_a = bcmw_pkg::ERR_LENGTH;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emitted_q <= '0;
		end else if (accept && err_a == bcmw_pkg::ERR_NONE &&
				(cmd == bcmw_pkg::CMD_COPY || cmd == bcmw_pkg::CMD_RAW_START)) begin
			emitted_q <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			cmd_s1 <= cmd;
			len_s1 <= byte_length;
			d_s1 <= base - dict_offset;
			err_s1 <= err_a;
			hdr_s1 <= (emitted_q == 32'd0);
			rv_s1 <= raw_value;
		end
	end

	// Stage two: length code, distance postfix, header and first trees.
	logic [1:0]  p_c;
	logic [26:0] dist_c;
	logic [4:0]  fl, bucket_c;
	logic [4:0]  code;
	logic [11:0] prev;
	logic [23:0] cx_c;
	logic [9:0]  icode;
	logic [2:0]  nib;
	logic [1:0]  mcode;
	logic [3:0]  wsel;
	logic [bcmw_pkg::BITS_W-1:0] acc;
	logic [bcmw_pkg::POS_W-1:0]  pos;

	always_comb begin
		if (28'(d_s1) <= bcmw_pkg::DIST_P0_MAX)
			p_c = 2'd0;
		else if (28'(d_s1) <= bcmw_pkg::DIST_P1_MAX)
			p_c = 2'd1;
		else if (28'(d_s1) <= bcmw_pkg::DIST_P2_MAX)
			p_c = 2'd2;
		else
			p_c = 2'd3;
		dist_c = (27'd1 << (3'(p_c) + 3'd2)) + 27'(d_s1) - 27'd1;
		fl = '0;
		for (int i = 1; i < 27; i++)
			if (dist_c[i])
				fl = 5'(i);
		bucket_c = fl - 5'd1;

		code = '0;
		for (int i = 0; i < 23; i++)
			if (len_s1 > 25'(bcmw_pkg::copy_maxl(5'(i))))
				code = 5'(i + 1);
		prev = (code == 5'd0) ? 12'd1 : bcmw_pkg::copy_maxl(code - 5'd1);
		cx_c = 24'(len_s1 - 25'(prev) - 25'd1);
		if (code <= 5'd7)
			icode = 10'd128 | 10'(code);
		else if (code <= 5'd15)
			icode = 10'd192 | 10'(code - 5'd8);
		else
			icode = 10'd384 | 10'(code - 5'd16);

		if (len_s1 <= 25'd65536) begin
			nib = 3'd4;
			mcode = 2'd0;
		end else if (len_s1 <= 25'd1048576) begin
			nib = 3'd5;
			mcode = 2'd1;
		end else begin
			nib = 3'd6;
			mcode = 2'd2;
		end
		if (cfg.window_log < 5'd10)
			wsel = 4'd0;
		else if (cfg.window_log > 5'd24)
			wsel = 4'd14;
		else
			wsel = 4'(cfg.window_log - 5'd10);

		acc = '0;
		pos = '0;
		if (hdr_s1) begin
			acc = bcmw_pkg::put_bits(acc, pos, 32'(bcmw_pkg::wh_val(wsel)),
				6'(bcmw_pkg::wh_len(wsel)));
			pos = pos + 8'(bcmw_pkg::wh_len(wsel));
		end
		acc = bcmw_pkg::put_bits(acc, pos, 32'({mcode, 1'b0}), 6'd3);
		pos = pos + 8'd3;
		acc = bcmw_pkg::put_bits(acc, pos, 32'(len_s1 - 25'd1), 6'({nib, 2'b00}));
		pos = pos + 8'({nib, 2'b00});
		if (cmd_s1 == bcmw_pkg::CMD_COPY) begin
			acc = bcmw_pkg::put_bits(acc, pos, 32'({p_c, 4'b0000}), 6'd14);
			pos = pos + 8'd14;
			acc = bcmw_pkg::put_bits(acc, pos, 32'd1, 6'd12);
			pos = pos + 8'd12;
			acc = bcmw_pkg::put_bits(acc, pos, 32'({icode, 4'b0001}), 6'd14);
			pos = pos + 8'd14;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			cmd_s2 <= cmd_s1;
			err_s2 <= err_s1;
			acc_s2 <= acc;
			pos_s2 <= pos;
			cx_s2 <= cx_c;
			nx_s2 <= bcmw_pkg::copy_xbits(code);
			p_s2 <= p_c;
			dist_s2 <= dist_c;
			bucket_s2 <= bucket_c;
			rv_s2 <= rv_s1;
		end
	end

	// Stage three: distance tree, copy and distance extra bits.
	logic        prefix;
	logic [26:0] postfix, off, dx;
	logic [4:0]  nbits;
	logic [9:0]  dsym;
	logic [bcmw_pkg::BITS_W-1:0] acc3;
	logic [bcmw_pkg::POS_W-1:0]  pos3;

	always_comb begin
		prefix = dist_s2[bucket_s2];
		postfix = dist_s2 & ((27'd1 << p_s2) - 27'd1);
		off = 27'(2'd2 + 2'(prefix)) << bucket_s2;
		nbits = bucket_s2 - 5'(p_s2);
		dsym = 10'd16 + 10'((10'({nbits - 5'd1, 1'b0}) + 10'(prefix)) << p_s2) +
			10'(postfix);
		dx = (dist_s2 - off) >> p_s2;

		acc3 = acc_s2;
		pos3 = pos_s2;
		entry = '0;
		entry.err = bcmw_pkg::err_t'(err_s2);
		if (err_s2 == bcmw_pkg::ERR_NONE) begin
			case (bcmw_pkg::cmd_t'(cmd_s2))
				bcmw_pkg::CMD_COPY: begin
					acc3 = bcmw_pkg::put_bits(acc3, pos3, 32'({dsym, 4'b0001}),
						6'd10 + 6'(p_s2));
					pos3 = pos3 + 8'd10 + 8'(p_s2);
					acc3 = bcmw_pkg::put_bits(acc3, pos3, 32'(cx_s2), 6'(nx_s2));
					pos3 = pos3 + 8'(nx_s2);
					acc3 = bcmw_pkg::put_bits(acc3, pos3, 32'(dx), 6'(nbits));
					pos3 = pos3 + 8'(nbits);
					entry.bits = acc3;
					entry.len = pos3;
				end
				bcmw_pkg::CMD_RAW_START: begin
					entry.bits = bcmw_pkg::put_bits(acc3, pos3, 32'd1, 6'd1);
					entry.len = pos3 + 8'd1;
					entry.pad = 1'b1;
				end
				bcmw_pkg::CMD_RAW_BYTE: begin
					entry.bits = bcmw_pkg::BITS_W'(rv_s2);
					entry.len = 8'd8;
				end
				default: begin
					entry.bits = bcmw_pkg::BITS_W'(2'b11);
					entry.len = 8'd2;
					entry.pad = 1'b1;
				end
			endcase
		end
	end

endmodule

// ===== hdl/bcmw_fifo.sv =====
// Two-word queue between the front part and the bit packer.
module bcmw_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  bcmw_pkg::entry_t wdata,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output bcmw_pkg::entry_t rdata
);

	bcmw_pkg::entry_t mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push)
				wptr_q <= !wptr_q;
			if (pop)
				rptr_q <= !rptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== hdl/bcmw_back.sv =====
// Back part: packs queued bit words into bytes and drives the output register.
module bcmw_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  bcmw_pkg::entry_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last,
	output logic [1:0]       error
);

	logic                       busy_q;
	logic [bcmw_pkg::SRC_W-1:0] buf_q;
	logic [8:0]                 rem_q;
	logic [7:0]                 pend_q;
	logic [2:0]                 fill_q;

	logic [bcmw_pkg::SRC_W-1:0] src;
	logic [8:0]       srcn, n, newn;
	logic             emit, is_err, lastb;

	always_comb begin
		n = 9'(fill_q) + 9'(head.len);
		if (head.pad)
			n = (n + 9'd7) & ~9'd7;
		src = busy_q ? buf_q :
			((bcmw_pkg::SRC_W'(head.bits) << fill_q) | bcmw_pkg::SRC_W'(pend_q));
		srcn = busy_q ? rem_q : n;
		newn = srcn - 9'd8;
		lastb = (newn < 9'd8);
		is_err = !busy_q && head.err != bcmw_pkg::ERR_NONE;
		emit = (!out_valid || out_ready) && (busy_q || !empty);
		pop = emit && !busy_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pend_q <= '0;
			fill_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
				if (!is_err) begin
					busy_q <= !lastb;
					if (lastb) begin
						pend_q <= src[15:8];
						fill_q <= newn[2:0];
					end
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (is_err) begin
				out_byte <= 8'd0;
				last <= 1'b1;
				error <= head.err;
			end else begin
				out_byte <= src[7:0];
				last <= lastb;
				error <= bcmw_pkg::ERR_NONE;
				buf_q <= src >> 8;
				rem_q <= newn;
			end
		end
	end

endmodule

// ===== tb/brotli_copy_metablock_writer_core_test.sv =====
// Self-checking testbench of the Brotli copy meta-block writer core.
module brotli_copy_metablock_writer_core_test;

	localparam int LIMIT = 1000000;

	typedef struct {
		logic [7:0]     data;
		logic           fin;
		bcmw_pkg::err_t err;
	} stream_word_t;

	class brotli_stream_model;
		logic [4:0]  wlog;
		logic [23:0] wbytes;
		logic [24:0] dbytes;
		logic [31:0] count;
		logic [7:0]  part;
		int          fill;
		logic [7:0]  bytes_out[24];
		int          nbytes;
		int          errors;
		stream_word_t expected_bytes[$];
		byte unsigned xbits[24] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 2, 2,
			3, 3, 4, 4, 5, 5, 6, 7, 8, 9, 10, 24};
		byte unsigned hdr_val[15] = '{8'h21, 8'h31, 8'h41, 8'h51, 8'h61, 8'h71, 8'h00,
			8'h01, 8'h03, 8'h05, 8'h07, 8'h09, 8'h0B, 8'h0D, 8'h0F};
		byte unsigned hdr_len[15] = '{7, 7, 7, 7, 7, 7, 1, 7, 4, 4, 4, 4, 4, 4, 4};

		function new();
			wlog = 22;
			wbytes = 24'd4194288;
			dbytes = 0;
			count = 0;
			part = 0;
			fill = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [24:0] val);
			if (idx == bcmw_pkg::REG_WINDOW_LOG) wlog = val[4:0];
			else if (idx == bcmw_pkg::REG_WINDOW_BYTES) wbytes = val[23:0];
			else if (idx == bcmw_pkg::REG_DICT_BYTES) dbytes = val;
		endfunction

		function longint unsigned base();
			return longint'(dbytes) + ((wbytes < count) ? wbytes : count);
		endfunction

		function void put(logic [31:0] v, int n);
			for (int i = 0; i < n; i++) begin
				part[fill] = v[i];
				fill++;
				if (fill == 8) begin
					if (nbytes < 24) begin
						bytes_out[nbytes] = part;
						nbytes++;
					end
					part = 0;
					fill = 0;
				end
			end
		endfunction

		function void bump(logic [31:0] n);
			longint unsigned s;
			s = longint'(count) + n;
			count = (s > 64'hFFFFFFFF) ? 32'hFFFFFFFF : s[31:0];
		endfunction

		function void block_header(logic [31:0] size);
			int nib, code, w;
			if (size <= 65536) begin nib = 4; code = 0; end
			else if (size <= 1048576) begin nib = 5; code = 1; end
			else begin nib = 6; code = 2; end
			if (count == 0) begin
				w = (wlog < 10) ? 10 : ((wlog > 24) ? 24 : wlog);
				put(hdr_val[w-10], hdr_len[w-10]);
			end
			put(0, 1);
			put(code, 2);
			put(size - 1, nib * 4);
		endfunction

		function void tree(logic [31:0] sym, int width);
			put(1, 2);
			put(0, 2);
			put(sym, width);
		endfunction

		function void copy_block(logic [31:0] len, longint unsigned d);
			int code, p, bucket, nbits, nx;
			logic [31:0] maxl, prev, cx, icode;
			longint unsigned dval, postfix, prefix, off, dsym, dx, t;
			code = 0;
			maxl = 2;
			prev = 1;
			while (!(len <= maxl || code == 23)) begin
				code++;
				prev = maxl;
				maxl += 32'd1 << xbits[code];
			end
			nx = xbits[code];
			cx = len - prev - 1;
			if (code <= 7) icode = 128 | code;
			else if (code <= 15) icode = 192 | (code - 8);
			else icode = 384 | (code - 16);
			if (d <= bcmw_pkg::DIST_P0_MAX) p = 0;
			else if (d <= bcmw_pkg::DIST_P1_MAX) p = 1;
			else if (d <= bcmw_pkg::DIST_P2_MAX) p = 2;
			else p = 3;
			dval = (64'd1 << (p + 2)) + d - 1;
			t = dval;
			bucket = 0;
			while (t > 1) begin
				t >>= 1;
				bucket++;
			end
			bucket = bucket - 1;
			postfix = dval & ((64'd1 << p) - 1);
			prefix = (dval >> bucket) & 1;
			off = (2 + prefix) << bucket;
			nbits = bucket - p;
			dsym = 16 + (((2 * (nbits - 1)) + prefix) << p) + postfix;
			dx = (dval - off) >> p;
			block_header(len);
			put(0, 4);
			put(p, 2);
			put(0, 4);
			put(0, 2);
			put(0, 2);
			tree(0, 8);
			tree(icode, 10);
			tree(32'(dsym & 64'h3FF), 6 + p);
			put(cx, nx);
			put(dx[31:0], nbits);
			bump(len);
		endfunction

		function void note_command(bcmw_pkg::cmd_t c, logic [25:0] offs, logic [24:0] len,
				logic [7:0] rv);
			bcmw_pkg::err_t e;
			longint unsigned b;
			int n;
			stream_word_t w;
			e = bcmw_pkg::ERR_NONE;
			nbytes = 0;
			case (c)
				bcmw_pkg::CMD_COPY: begin
					b = base();
					if (len < 2 || len > bcmw_pkg::MAX_BLOCK_LEN) e = bcmw_pkg::ERR_LENGTH;
					else if (offs >= b) e = bcmw_pkg::ERR_DISTANCE;
					else copy_block(len, b - offs);
				end
				bcmw_pkg::CMD_RAW_START: begin
					if (len == 0 || len > bcmw_pkg::MAX_BLOCK_LEN) begin
						e = bcmw_pkg::ERR_LENGTH;
					end else begin
						block_header(len);
						put(1, 1);
						if (fill != 0) put(0, 8 - fill);
						bump(len);
					end
				end
				bcmw_pkg::CMD_RAW_BYTE: put(rv, 8);
				default: begin
					put(1, 1);
					put(1, 1);
					if (fill != 0) put(0, 8 - fill);
				end
			endcase
			if (e != bcmw_pkg::ERR_NONE) begin
				w.data = 0;
				w.fin = 1;
				w.err = e;
				expected_bytes.push_back(w);
			end else begin
				n = (nbytes > 20) ? 20 : nbytes;
				for (int k = 0; k < n; k++) begin
					w.data = bytes_out[k];
					w.fin = (k == n - 1);
					w.err = bcmw_pkg::ERR_NONE;
					expected_bytes.push_back(w);
				end
			end
		endfunction

		task report(string what);
			errors++;
			$display("MISMATCH: %s", what);
		endtask

		task check_byte(logic [7:0] data, logic fin, logic [1:0] err);
			stream_word_t w;
			if (expected_bytes.size() == 0) begin
				report($sformatf("unexpected word %h last %b error %0d", data, fin, err));
			end else begin
				w = expected_bytes.pop_front();
				if (data !== w.data || fin !== w.fin || err !== w.err)
					report($sformatf("got %h/%b/%0d expected %h/%b/%0d",
						data, fin, err, w.data, w.fin, w.err));
			end
		endtask
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	logic [1:0]  cmd = 0;
	logic [25:0] dict_offset = 0;
	logic [24:0] byte_length = 0;
	logic [7:0]  raw_value = 0;
	logic        out_valid;
	logic        out_ready = 0;
	logic [7:0]  out_byte;
	logic        last;
	logic [1:0]  error;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = 0;
	logic [24:0] cfg_data = 0;

	brotli_stream_model sb = new();
	bit quiet = 0;
	bit idling = 1;
	int cycles = 0;
	int stall_left = 0;

	brotli_copy_metablock_writer_core u_top (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_byte(out_byte, last, error);
			if (in_valid && in_ready)
				sb.note_command(bcmw_pkg::cmd_t'(cmd), dict_offset, byte_length, raw_value);
			if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
		end
	end

	// Receiver stalls come in bursts; none in the quiet tail of the run.
	always @(negedge clk) begin
		if (quiet || !arst_n) begin
			out_ready <= !quiet ? 1'b0 : 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_ready <= 0;
		end else begin
			out_ready <= 1;
		end
	end

	task send(bcmw_pkg::cmd_t c, logic [25:0] offs, logic [24:0] len, logic [7:0] rv);
		int gap;
		@(negedge clk);
		if (idling && !quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 9);
			in_valid <= 0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		dict_offset <= offs;
		byte_length <= len;
		raw_value <= rv;
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
	endtask

	task drain();
		@(negedge clk);
		in_valid <= 0;
		while (sb.expected_bytes.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [24:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task set_all(logic [4:0] wl, logic [23:0] wb, logic [24:0] db);
		drain();
		write_reg(bcmw_pkg::REG_WINDOW_LOG, 25'(wl));
		write_reg(bcmw_pkg::REG_WINDOW_BYTES, 25'(wb));
		write_reg(bcmw_pkg::REG_DICT_BYTES, db);
	endtask

	task send_copy();
		longint unsigned b;
		logic [24:0] len;
		logic [25:0] offs;
		b = sb.base();
		if ($urandom_range(0, 15) == 0) len = 25'($urandom_range(2, bcmw_pkg::MAX_BLOCK_LEN));
		else if ($urandom_range(0, 3) == 0) len = 25'($urandom_range(2, 2200));
		else len = 25'($urandom_range(2, 300));
		if (b == 0) offs = 26'($urandom);
		else if ($urandom_range(0, 1) == 0)
			offs = 26'(b - $urandom_range(1, (b > 64) ? 64 : 32'(b)));
		else offs = 26'($urandom_range(0, 32'(b - 1)));
		send(bcmw_pkg::CMD_COPY, offs, len, 8'($urandom));
	endtask

	task random_phase(int n);
		int done, k;
		done = 0;
		while (done < n) begin
			k = $urandom_range(0, 99);
			if (k < 55) begin
				send_copy();
				done++;
			end else if (k < 75) begin
				send(bcmw_pkg::CMD_RAW_START, 26'($urandom), 25'($urandom_range(1, 5000)),
					8'($urandom));
				done++;
				repeat ($urandom_range(1, 6)) begin
					send(bcmw_pkg::CMD_RAW_BYTE, 26'($urandom), 25'($urandom), 8'($urandom));
					done++;
				end
			end else if (k < 85) begin
				send(bcmw_pkg::CMD_END, 26'($urandom), 25'($urandom), 8'($urandom));
				done++;
			end else begin
				send(bcmw_pkg::cmd_t'(2'($urandom_range(0, 3))), 26'($urandom),
					25'($urandom), 8'($urandom));
				done++;
			end
		end
	endtask

	initial begin
		longint unsigned b;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		// Empty dictionary and nothing written: the end command carries no window header and every copy is rejected.
		send(bcmw_pkg::CMD_END, 0, 0, 0);
		send(bcmw_pkg::CMD_COPY, 0, 5, 0);
		send(bcmw_pkg::CMD_COPY, 0, 0, 0);
		send(bcmw_pkg::CMD_COPY, 0, 1, 0);
		send(bcmw_pkg::CMD_COPY, 26'h3FFFFFF, 25'h1FFFFFF, 0);
		send(bcmw_pkg::CMD_RAW_START, 0, 0, 0);
		send(bcmw_pkg::CMD_RAW_START, 0, 25'(bcmw_pkg::MAX_BLOCK_LEN + 1), 0);
		send(bcmw_pkg::CMD_RAW_START, 0, 3, 0);
		send(bcmw_pkg::CMD_RAW_BYTE, 0, 0, 8'h00);
		send(bcmw_pkg::CMD_RAW_BYTE, 26'h3FFFFFF, 25'h1FFFFFF, 8'hFF);
		send(bcmw_pkg::CMD_RAW_BYTE, 0, 0, 8'hA5);
		send(bcmw_pkg::CMD_RAW_START, 0, 25'(bcmw_pkg::MAX_BLOCK_LEN), 0);
		send(bcmw_pkg::CMD_RAW_BYTE, 0, 0, 8'h5A);
		set_all(22, 24'd4194288, 25'd100);
		b = sb.base();
		send(bcmw_pkg::CMD_COPY, 26'(b - 1), 2, 0);
		send(bcmw_pkg::CMD_COPY, 0, 25'(bcmw_pkg::MAX_BLOCK_LEN), 0);
		send(bcmw_pkg::CMD_COPY, 0, 2117, 0);
		send(bcmw_pkg::CMD_COPY, 0, 2118, 0);
		send(bcmw_pkg::CMD_COPY, 3, 9, 0);
		send(bcmw_pkg::CMD_COPY, 3, 10, 0);
		send(bcmw_pkg::CMD_COPY, 26'(sb.base()), 4, 0);
		send(bcmw_pkg::CMD_COPY, 26'h3FFFFFF, 4, 0);
		send(bcmw_pkg::CMD_COPY, 7, 3, 0);
		// A copy leaves the stream unaligned, so this byte straddles two words.
		send(bcmw_pkg::CMD_RAW_BYTE, 0, 0, 8'hC3);
		send(bcmw_pkg::CMD_END, 0, 0, 0);

		set_all(10, 24'd0, 25'd16777216);
		random_phase(100);
		drain();
		random_phase(10);
		set_all(31, 24'd16777200, 25'd1000);
		random_phase(100);
		set_all(0, 24'd1234, 25'd5);
		random_phase(100);
		set_all(5'($urandom), 24'($urandom_range(0, 16777200)),
			25'($urandom_range(0, 16777216)));
		quiet = 1;
		random_phase(80);

		drain();
		repeat (20) @(posedge clk);
		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

// ===== brotli_copy_metablock_writer_core.f =====
hdl/bcmw_pkg.sv
hdl/bcmw_front.sv
hdl/bcmw_fifo.sv
hdl/bcmw_back.sv
hdl/brotli_copy_metablock_writer_core.sv
tb/brotli_copy_metablock_writer_core_test.sv
